### rtl/pfbgr_pkg.sv
// ----------------------------------------------------------------------------
// pfbgr_pkg
// Shared types and constants of the pixel format to BGR24 converter.
// ----------------------------------------------------------------------------
package pfbgr_pkg;

   localparam int SIZE_W      = 13;   // image_width / image_height registers
   localparam int ROW_W       = 13;   // output row number
   localparam int COL3_W      = 15;   // column times three
   localparam int LINE_W      = 15;   // padded bytes per line
   localparam int ADDR_W      = 26;   // destination byte address
   localparam int PROD_W      = ROW_W + LINE_W;
   localparam int CSR_ADDR_W  = 4;
   localparam int CSR_DATA_W  = 32;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int QCNT_W      = 3;

   typedef enum logic [2:0] {
      FMT_32BPP = 3'd0,
      FMT_24BPP = 3'd1,
      FMT_565   = 3'd2,
      FMT_555   = 3'd3,
      FMT_PAL8  = 3'd4
   } fmt_type;

   typedef enum logic [1:0] {
      REG_WIDTH  = 2'd0,
      REG_HEIGHT = 2'd1,
      REG_FORMAT = 2'd2,
      REG_FLIP   = 2'd3
   } reg_idx_type;

   typedef enum logic {
      KIND_PIXEL   = 1'b0,
      KIND_PALETTE = 1'b1
   } kind_type;

   typedef struct packed {
      logic        kind;
      logic [31:0] pixel_value;
      logic [7:0]  palette_index;
      logic [7:0]  palette_red;
      logic [7:0]  palette_green;
      logic [7:0]  palette_blue;
   } req_type;

   typedef struct packed {
      logic [ADDR_W-1:0] dest_address;
      logic [7:0]        out_blue;
      logic [7:0]        out_green;
      logic [7:0]        out_red;
      logic              frame_last;
   } rsp_type;

   typedef struct packed {
      logic [SIZE_W-1:0] image_width;
      logic [SIZE_W-1:0] image_height;
      logic [2:0]        source_format;
      logic              flip_rows;
   } cfg_type;

   // queue entry: a palette write carries {index, red, green, blue} in data
   typedef struct packed {
      logic              is_palette;
      logic [31:0]       data;
      logic [ROW_W-1:0]  out_row;
      logic [COL3_W-1:0] col3;
      logic              last;
   } qent_type;

   typedef struct packed {
      logic     valid;
      qent_type entry;
   } qhead_type;

endpackage

### rtl/pixel_format_to_bgr24_converter_top.sv
// ----------------------------------------------------------------------------
// pixel_format_to_bgr24_converter_top
// Converts 32/24/16/15 bpp and palette pixels to BGR bytes with their
// destination address in a padded, optionally row-flipped image.
// ----------------------------------------------------------------------------
// path: an accepted pixel is registered in the queue, then in the palette read stage and the output register
// throughput: one item per cycle while rsp_ready holds, through the combinational front stage,
//   the four-entry queue and the two-stage back pipeline (palette read, output)
// reset: registers return to width 1, height 1, 32 bpp, no flip; position
//   counters clear; palette valid bits clear at once, so all entries read black
module pixel_format_to_bgr24_converter_top #(
   parameter int MAX_WIDTH       = 4096,
   parameter int MAX_HEIGHT      = 4096,
   parameter int PALETTE_ENTRIES = 256
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  pfbgr_pkg::req_type                    req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output pfbgr_pkg::rsp_type                    rsp_data,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [pfbgr_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [pfbgr_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [pfbgr_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                  csr_pready
);
   import pfbgr_pkg::*;

   cfg_type     cfg_ff, cfg_in;
   logic        csr_write;
   logic        queue_full;
   logic        push;
   qent_type    push_entry;
   logic        pop;
   qhead_type   head;
   logic [12:0] wdata13;
   logic [12:0] width_clamped;
   logic [12:0] height_clamped;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign wdata13    = csr_pwdata[12:0];

   // zero is taken as one; the low 13 bits saturate at the maximum
   always_comb begin
      if (wdata13 == 13'd0) begin
         width_clamped = 13'd1;
      end else if (32'(wdata13) > 32'(MAX_WIDTH)) begin
         width_clamped = 13'(MAX_WIDTH);
      end else begin
         width_clamped = wdata13;
      end
      if (wdata13 == 13'd0) begin
         height_clamped = 13'd1;
      end else if (32'(wdata13) > 32'(MAX_HEIGHT)) begin
         height_clamped = 13'(MAX_HEIGHT);
      end else begin
         height_clamped = wdata13;
      end
   end

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_paddr[3:2])
            REG_WIDTH:  cfg_in.image_width   = width_clamped;
            REG_HEIGHT: cfg_in.image_height  = height_clamped;
            REG_FORMAT: cfg_in.source_format = csr_pwdata[2:0];
            REG_FLIP:   cfg_in.flip_rows     = csr_pwdata[0];
            default:    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.image_width   <= 13'd1;
         cfg_ff.image_height  <= 13'd1;
         cfg_ff.source_format <= FMT_32BPP;
         cfg_ff.flip_rows     <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         REG_WIDTH:  csr_prdata = 32'(cfg_ff.image_width);
         REG_HEIGHT: csr_prdata = 32'(cfg_ff.image_height);
         REG_FORMAT: csr_prdata = 32'(cfg_ff.source_format);
         REG_FLIP:   csr_prdata = 32'(cfg_ff.flip_rows);
         default:    csr_prdata = '0;
      endcase
   end

   pfbgr_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .cfg        (cfg_ff),
      .restart    (csr_write),
      .queue_full (queue_full),
      .push       (push),
      .push_entry (push_entry)
   );

   pfbgr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .head       (head)
   );

   pfbgr_back #(
      .PALETTE_ENTRIES (PALETTE_ENTRIES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .head      (head),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

### rtl/pfbgr_front.sv
// ----------------------------------------------------------------------------
// pfbgr_front
// Accepts items, drops pixels of unhandled formats, tracks the raster
// position and forms the row and column terms of the destination address.
// ----------------------------------------------------------------------------
module pfbgr_front #(
   parameter int MAX_WIDTH  = 4096,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  pfbgr_pkg::req_type req_data,
   input  pfbgr_pkg::cfg_type cfg,
   input  logic               restart,
   input  logic               queue_full,
   output logic               push,
   output pfbgr_pkg::qent_type push_entry
);
   import pfbgr_pkg::*;

   localparam int CW   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int RW   = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int CMPW = 18;

   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;
   logic          accept;
   logic          fmt_ok;
   logic          is_pixel;
   logic          row_end;
   logic          frame_end;

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;
   assign is_pixel  = (req_data.kind == KIND_PIXEL);
   assign fmt_ok    = cfg.source_format inside {FMT_32BPP, FMT_24BPP, FMT_565, FMT_555,
                                                FMT_PAL8};
   assign push      = accept && (!is_pixel || fmt_ok);

   assign row_end   = (CMPW'(col_ff) + CMPW'(1)) >= CMPW'(cfg.image_width);
   assign frame_end = row_end && ((CMPW'(row_ff) + CMPW'(1)) >= CMPW'(cfg.image_height));

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (restart) begin
         col_in = '0;
         row_in = '0;
      end else if (push && is_pixel) begin
         if (row_end) begin
            col_in = '0;
            row_in = frame_end ? '0 : RW'(row_ff + RW'(1));
         end else begin
            col_in = CW'(col_ff + CW'(1));
         end
      end
   end

   always_comb begin
      push_entry.is_palette = !is_pixel;
      push_entry.data       = is_pixel ? req_data.pixel_value
                                       : {req_data.palette_index, req_data.palette_red,
                                          req_data.palette_green, req_data.palette_blue};
      push_entry.out_row    = cfg.flip_rows
                              ? ROW_W'(cfg.image_height - SIZE_W'(1) - SIZE_W'(row_ff))
                              : ROW_W'(row_ff);
      push_entry.col3       = (COL3_W'(col_ff) << 1) + COL3_W'(col_ff);
      push_entry.last       = frame_end;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

endmodule

### rtl/pfbgr_queue.sv
// ----------------------------------------------------------------------------
// pfbgr_queue
// Short first-in first-out queue between the front and the back part.
// ----------------------------------------------------------------------------
module pfbgr_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  pfbgr_pkg::qent_type   push_entry,
   output logic                  full,
   input  logic                  pop,
   output pfbgr_pkg::qhead_type  head
);
   import pfbgr_pkg::*;

   qent_type          slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_push;
   logic              do_pop;

   assign full        = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign head.valid  = (count_ff != '0);
   assign head.entry  = slot_ff[rd_ptr_ff];
   assign do_push     = push && !full;
   assign do_pop      = pop && head.valid;

   always_comb begin
      wr_ptr_in = do_push ? QPTR_W'(wr_ptr_ff + QPTR_W'(1)) : wr_ptr_ff;
      rd_ptr_in = do_pop ? QPTR_W'(rd_ptr_ff + QPTR_W'(1)) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = QCNT_W'(count_ff + QCNT_W'(1));
      end else if (do_pop && !do_push) begin
         count_in = QCNT_W'(count_ff - QCNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

### rtl/pfbgr_back.sv
// ----------------------------------------------------------------------------
// pfbgr_back
// Executes queued items: palette writes and lookups, channel expansion,
// destination address and the output register.
// ----------------------------------------------------------------------------
module pfbgr_back #(
   parameter int PALETTE_ENTRIES = 256
) (
   input  logic                 clock,
   input  logic                 reset,
   input  pfbgr_pkg::cfg_type   cfg,
   input  pfbgr_pkg::qhead_type head,
   output logic                 pop,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output pfbgr_pkg::rsp_type   rsp_data
);
   import pfbgr_pkg::*;

   localparam int PW = $clog2(PALETTE_ENTRIES);

   logic [23:0]                pal_mem [PALETTE_ENTRIES];
   logic [PALETTE_ENTRIES-1:0] pal_vld_ff;

   qent_type    a_ent_ff;
   logic        a_valid_ff, a_valid_in;
   logic [23:0] a_pal_ff;
   logic        a_hit_ff;

   rsp_type     out_ff, out_in;
   logic        out_valid_ff, out_valid_in;

   logic              advance;
   logic              a_free;
   logic              load_a;
   logic              pal_wr;
   logic [7:0]        wr_idx;
   logic [7:0]        rd_idx;
   logic              wr_in_range;
   logic              rd_in_range;
   logic [LINE_W-1:0] line_bytes;
   logic [PROD_W-1:0] row_offset;
   logic [PROD_W-1:0] addr_sum;
   logic [31:0]       p;
   logic [23:0]       pal;
   logic [7:0]        blue, green, red;

   assign advance     = !out_valid_ff || rsp_ready;
   assign a_free      = !a_valid_ff || advance;
   // palette writes need no slot in the pipeline, so they drain at any time
   assign pop         = head.valid && (head.entry.is_palette || a_free);
   assign load_a      = pop && !head.entry.is_palette;
   assign wr_idx      = head.entry.data[31:24];
   assign rd_idx      = head.entry.data[7:0];
   assign wr_in_range = {1'b0, wr_idx} < 9'(PALETTE_ENTRIES);
   assign rd_in_range = {1'b0, rd_idx} < 9'(PALETTE_ENTRIES);
   assign pal_wr      = pop && head.entry.is_palette && wr_in_range;

   assign a_valid_in   = load_a ? 1'b1 : (advance ? 1'b0 : a_valid_ff);
   assign out_valid_in = advance ? a_valid_ff : out_valid_ff;

   always_ff @(posedge clock) begin
      if (pal_wr) begin
         pal_mem[PW'(wr_idx)] <= head.entry.data[23:0];
      end
      if (load_a) begin
         a_ent_ff <= head.entry;
         a_pal_ff <= pal_mem[PW'(rd_idx)];
         a_hit_ff <= rd_in_range && pal_vld_ff[PW'(rd_idx)];
      end
   end

   // entries never written read as black
   always_ff @(posedge clock) begin
      if (reset) begin
         pal_vld_ff <= '0;
      end else if (pal_wr) begin
         pal_vld_ff[PW'(wr_idx)] <= 1'b1;
      end
   end

   // channel expansion
   always_comb begin
      p   = a_ent_ff.data;
      pal = a_hit_ff ? a_pal_ff : 24'd0;
      case (cfg.source_format)
         FMT_32BPP, FMT_24BPP: begin
            blue  = p[7:0];
            green = p[15:8];
            red   = p[23:16];
         end
         FMT_565: begin
            red   = {p[15:11], p[15:13]};
            green = {p[10:5], p[10:9]};
            blue  = {p[4:0], p[4:2]};
         end
         FMT_555: begin
            red   = {p[14:10], p[14:12]};
            green = {p[9:5], p[9:7]};
            blue  = {p[4:0], p[4:2]};
         end
         FMT_PAL8: begin
            red   = pal[23:16];
            green = pal[15:8];
            blue  = pal[7:0];
         end
         default: begin
            red   = 8'd0;
            green = 8'd0;
            blue  = 8'd0;
         end
      endcase
   end

   // rows padded to a multiple of four bytes
   always_comb begin
      line_bytes      = (LINE_W'(cfg.image_width) << 1) + LINE_W'(cfg.image_width)
                        + LINE_W'(3);
      line_bytes[1:0] = 2'b00;
      row_offset      = PROD_W'(a_ent_ff.out_row) * PROD_W'(line_bytes);
      addr_sum        = row_offset + PROD_W'(a_ent_ff.col3);
   end

   always_comb begin
      out_in              = out_ff;
      if (advance && a_valid_ff) begin
         out_in.dest_address = addr_sum[ADDR_W-1:0];
         out_in.out_blue     = blue;
         out_in.out_green    = green;
         out_in.out_red      = red;
         out_in.frame_last   = a_ent_ff.last;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         a_valid_ff   <= a_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule
